[hdl/gtp_pkg.sv]
// Package: widths, constants and the CORDIC arctangent table for the go-to-pose controller.
package gtp_pkg;

    localparam int MAX_STEPS      = 24;
    localparam int DEF_STEPS      = 16;
    localparam int CW             = 38;   // CORDIC datapath width
    localparam int ZW             = 26;   // fine angle width, pi = 2^23
    localparam int IDX_W          = 3;

    localparam logic [ZW-1:0] ANG_PI_FINE = ZW'(8388608);

    typedef enum logic [1:0] {
        ACT_TURN_GOAL  = 2'd0,
        ACT_DRIVE      = 2'd1,
        ACT_TURN_FINAL = 2'd2,
        ACT_STOP       = 2'd3
    } t_action;

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_X  = 3'd0,
        REG_TARGET_Y  = 3'd1,
        REG_TARGET_H  = 3'd2,
        REG_POS_TOL   = 3'd3,
        REG_BEAR_TOL  = 3'd4,
        REG_ORIENT_TOL = 3'd5,
        REG_DRIVE     = 3'd6,
        REG_TURN      = 3'd7
    } t_reg_idx;

    // atan(2^-i), pi = 2^23
    function automatic logic [ZW-1:0] atan_fine(input int i);
        logic [ZW-1:0] v;
        unique case (i)
            0: v = ZW'(2097152);  1: v = ZW'(1238021);  2: v = ZW'(654136);
            3: v = ZW'(332050);   4: v = ZW'(166669);   5: v = ZW'(83416);
            6: v = ZW'(41718);    7: v = ZW'(20860);    8: v = ZW'(10430);
            9: v = ZW'(5215);     10: v = ZW'(2608);    11: v = ZW'(1304);
            12: v = ZW'(652);     13: v = ZW'(326);     14: v = ZW'(163);
            15: v = ZW'(81);      16: v = ZW'(41);      17: v = ZW'(20);
            18: v = ZW'(10);      19: v = ZW'(5);       20: v = ZW'(3);
            21: v = ZW'(1);       22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/gtp_cordic.sv]
// Pipelined vectoring CORDIC atan2, one stage per iteration, result pi = 32768.
module gtp_cordic #(
    parameter int STEPS = gtp_pkg::DEF_STEPS
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [gtp_pkg::CW-1:0] i_y,
    input  logic signed [gtp_pkg::CW-1:0] i_x,
    output logic signed [16:0]      o_ang
);
    import gtp_pkg::*;

    localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic signed [ZW-1:0] r_z [NS+1];
    logic                 r_zero_d [NS+1];
    logic                 r_neg_d  [NS+1];
    logic signed [16:0]   r_ang;
    logic signed [ZW-1:0] w_zc;
    logic signed [ZW-1:0] w_zr;

    // pre-rotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero_d[0] <= (i_y == '0);
            r_neg_d[0]  <= (i_x < 0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y > 0) ? $signed(ANG_PI_FINE) : -$signed(ANG_PI_FINE);
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero_d[i+1] <= r_zero_d[i];
                r_neg_d[i+1]  <= r_neg_d[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed(atan_fine(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed(atan_fine(i));
                end
            end
        end
    end

    always_comb begin
        w_zc = r_z[NS];
        if (w_zc > $signed(ANG_PI_FINE)) w_zc = $signed(ANG_PI_FINE);
        if (w_zc < -$signed(ANG_PI_FINE)) w_zc = -$signed(ANG_PI_FINE);
        w_zr = w_zc + ZW'(128);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero_d[NS]) r_ang <= r_neg_d[NS] ? 17'sd32768 : 17'sd0;
            else              r_ang <= 17'(w_zr >>> 8);
        end
    end

    assign o_ang = r_ang;
endmodule

[hdl/go_to_pose_bang_bang_controller.sv]
// Top level: go-to-pose turn-then-drive controller with a deep pipeline.
// Usage:
//  - Pose words enter on s_axis (tvalid/tready/tdata); one decision word per
//    pose leaves on m_axis. tdata in: pos_x, pos_y, quat_x, quat_y, quat_z, quat_w.
//  - tdata out: action[1:0], linear_cmd[17:2], angular_cmd[33:18], zero pad.
//  - Goal, tolerances and speeds are written through i_cfg_we/i_cfg_idx/
//    i_cfg_data while the block is idle.
//  - Throughput: one word per cycle while the receiver takes results. Each word
//    passes through input products, CORDIC pre-rotation, one stage per iteration,
//    rounding, compare and decision registers of the unrolled CORDIC chain.
//  - The whole pipeline advances only when the output register is free or
//    being read, so a stalled receiver freezes every stage; nothing is lost.
//  - s_axis_tready follows the pipeline enable: it drops exactly while a
//    result waits and the receiver holds m_axis_tready low.
//  - Reset (synchronous, active low) clears all valid bits and loads the
//    default register values.
module go_to_pose_bang_bang_controller #(
    parameter int CORDIC_STEPS = gtp_pkg::DEF_STEPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // action, linear_cmd, angular_cmd, pad
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import gtp_pkg::*;

    localparam int NS  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int LAT = NS + 2;   // products + cordic stages

    // configuration
    logic signed [31:0] r_tx, r_ty;
    logic signed [15:0] r_th;
    logic [30:0]        r_ptol;
    logic [15:0]        r_btol, r_otol, r_spd, r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= '0; r_ty <= '0; r_th <= '0;
            r_ptol <= 31'd13107; r_btol <= 16'd910; r_otol <= 16'd1820;
            r_spd <= 16'd768; r_rate <= 16'd12868;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TARGET_X:   r_tx   <= i_cfg_data;
                REG_TARGET_Y:   r_ty   <= i_cfg_data;
                REG_TARGET_H:   r_th   <= i_cfg_data[15:0];
                REG_POS_TOL:    r_ptol <= i_cfg_data[30:0];
                REG_BEAR_TOL:   r_btol <= i_cfg_data[15:0];
                REG_ORIENT_TOL: r_otol <= i_cfg_data[15:0];
                REG_DRIVE:      r_spd  <= i_cfg_data[15:0];
                REG_TURN:       r_rate <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_ov;
    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [31:0] px, py;
    logic signed [15:0] qx, qy, qz, qw;
    assign px = s_axis_tdata[31:0];
    assign py = s_axis_tdata[63:32];
    assign qx = s_axis_tdata[79:64];
    assign qy = s_axis_tdata[95:80];
    assign qz = s_axis_tdata[111:96];
    assign qw = s_axis_tdata[127:112];

    // stage 1: quaternion products and goal differences
    logic signed [31:0] r_wz, r_xy, r_yy, r_zz;
    logic signed [32:0] r_dx, r_dy;
    logic [32:0]        r_adx, r_ady;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wz <= qw * qz;  r_xy <= qx * qy;
            r_yy <= qy * qy;  r_zz <= qz * qz;
            r_dx <= 33'(r_tx) - 33'(px);
            r_dy <= 33'(r_ty) - 33'(py);
            r_adx <= (33'(r_tx) - 33'(px)) < 0 ? 33'(33'(px) - 33'(r_tx))
                                               : 33'(33'(r_tx) - 33'(px));
            r_ady <= (33'(r_ty) - 33'(py)) < 0 ? 33'(33'(py) - 33'(r_ty))
                                               : 33'(33'(r_ty) - 33'(py));
        end
    end

    logic signed [CW-1:0] yaw_y, yaw_x;
    assign yaw_y = (CW'(r_wz) + CW'(r_xy)) <<< 1;
    assign yaw_x = (CW'(1) <<< 28) - ((CW'(r_yy) + CW'(r_zz)) <<< 1);

    logic signed [16:0] yaw, bear;
    gtp_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_y(yaw_y), .i_x(yaw_x), .o_ang(yaw));
    gtp_cordic #(.STEPS(CORDIC_STEPS)) u_bear (
        .i_clk(i_clk), .i_en(en), .i_y(CW'(r_dy)), .i_x(CW'(r_dx)), .o_ang(bear));

    // distance flags travel alongside the CORDIC
    logic [LAT:0] r_v;
    logic         r_far [2:LAT+1];
    logic         r_near[2:LAT+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en)  r_v <= {r_v[LAT-1:0], s_axis_tvalid};
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_far[2]  <= (r_adx > 33'(r_ptol)) || (r_ady > 33'(r_ptol));
            r_near[2] <= (r_adx < 33'(r_ptol)) && (r_ady < 33'(r_ptol));
        end
    end
    for (genvar k = 3; k <= LAT + 1; k++) begin : g_flag
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_far[k]  <= r_far[k-1];
                r_near[k] <= r_near[k-1];
            end
        end
    end

    // compare stage: errors against tolerances
    logic [16:0] eb, eo;
    logic signed [17:0] db, dd;
    assign db = 18'(bear) - 18'(yaw);
    assign dd = 18'(r_th) - 18'(yaw);
    assign eb = db < 0 ? 17'(-db) : 17'(db);
    assign eo = dd < 0 ? 17'(-dd) : 17'(dd);

    logic r_cv, r_bgt, r_blt, r_ogt, r_cfar, r_cnear;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (en)  r_cv <= r_v[LAT];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bgt   <= eb > 17'(r_btol);
            r_blt   <= eb < 17'(r_btol);
            r_ogt   <= eo > 17'(r_otol);
            r_cfar  <= r_far[LAT+1];
            r_cnear <= r_near[LAT+1];
        end
    end

    // decision and output register
    t_action act;
    always_comb begin
        priority if (r_bgt && r_cfar)   act = ACT_TURN_GOAL;
        else if (r_cfar && r_blt)       act = ACT_DRIVE;
        else if (r_cnear && r_ogt)      act = ACT_TURN_FINAL;
        else                            act = ACT_STOP;
    end

    logic [39:0] r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= r_cv;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_od <= {6'd0,
                     (act == ACT_TURN_GOAL || act == ACT_TURN_FINAL) ? r_rate : 16'd0,
                     (act == ACT_DRIVE) ? r_spd : 16'd0,
                     act};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_od)) else $error("result lost");
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_od[1:0] == ACT_DRIVE |-> r_od[33:18] == 16'd0)
        else $error("turn during drive");
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_od[1:0] == ACT_STOP |-> r_od[33:2] == 32'd0)
        else $error("motion in stop");
endmodule
